[rtl/rau_pkg.sv]
// rau_pkg: shared types and constants of the rational arithmetic unit
// action codes, item kinds, sequencer states and result field widths
// no dependencies
`timescale 1ns / 1ps

package rau_pkg;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  localparam int unsigned ACT_W       = 3;
  localparam int unsigned OUT_W       = 33;
  localparam int unsigned ORD_W       = 2;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic signed [ORD_W-1:0] ORD_LESS = 2'sb11;
  localparam logic signed [ORD_W-1:0] ORD_EQ   = 2'sb00;
  localparam logic signed [ORD_W-1:0] ORD_GT   = 2'sb01;

  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_CMP,
    KIND_BAD
  } kind_e;

  localparam int unsigned KIND_W = 3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GCD_GO,
    S_GCD_WAIT,
    S_Q1_GO,
    S_Q1_WAIT,
    S_Q2_GO,
    S_Q2_WAIT,
    S_M1,
    S_M2,
    S_M3,
    S_FORM,
    S_RCHK,
    S_RN_GO,
    S_RN_WAIT,
    S_RD_GO,
    S_RD_WAIT,
    S_OUT
  } state_e;

endpackage

[rtl/rau_fifo.sv]
// rau_fifo: small register queue between the front and the back
// depends on nothing
`timescale 1ns / 1ps

module rau_fifo #(
  parameter int unsigned WIDTH = 67,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

[rtl/rau_div.sv]
// rau_div: iterative signed divider, one quotient bit per cycle
// truncating quotient, remainder takes the dividend sign; no dependencies
`timescale 1ns / 1ps

module rau_div #(
  parameter int unsigned DW = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic signed [DW-1:0] divisor_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quot_o,
  output logic signed [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] a_q, b_q;
  logic [DW:0]   r_q, rs, r_nxt;
  logic          qneg_q, rneg_q, ge;

  assign rs    = {r_q[DW-1:0], a_q[DW-1]};
  assign ge    = (rs >= {1'b0, b_q});
  assign r_nxt = ge ? (rs - {1'b0, b_q}) : rs;

  assign done_o = done_q;
  assign quot_o = qneg_q ? -$signed(a_q) : $signed(a_q);
  assign rem_o  = rneg_q ? -$signed(r_q[DW-1:0]) : $signed(r_q[DW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= dividend_i[DW-1] ? -dividend_i : dividend_i;
      b_q    <= divisor_i[DW-1] ? -divisor_i : divisor_i;
      r_q    <= '0;
      qneg_q <= dividend_i[DW-1] ^ divisor_i[DW-1];
      rneg_q <= dividend_i[DW-1];
    end else if (busy_q) begin
      r_q <= r_nxt;
      a_q <= {a_q[DW-2:0], ge};
    end
  end

endmodule

[rtl/rau_front.sv]
// rau_front: accepts input items, classifies them and pushes them into the queue
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_front #(
  parameter int unsigned W    = 16,
  parameter int unsigned IN_W = 64
) (
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  input  logic [IN_W-1:0]         s_tdata_i,
  input  logic [rau_pkg::ACT_W-1:0] s_tuser_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [rau_pkg::KIND_W+4*W-1:0] wdata_o
);

  import rau_pkg::*;

  logic signed [W-1:0] an, ad, bn, bd;
  kind_e               kind;

  assign an = s_tdata_i[W-1:0];
  assign ad = s_tdata_i[2*W-1:W];
  assign bn = s_tdata_i[3*W-1:2*W];
  assign bd = s_tdata_i[4*W-1:3*W];

  always_comb begin
    case (s_tuser_i)
      ACT_ADD: kind = KIND_ADD;
      ACT_SUB: kind = KIND_SUB;
      ACT_MUL: kind = KIND_MUL;
      ACT_DIV: kind = KIND_DIV;
      ACT_CMP: kind = KIND_CMP;
      default: kind = KIND_BAD;
    endcase
    // zero denominators and division by a zero value give no result value
    if (ad == '0 || bd == '0 || (kind == KIND_DIV && bn == '0)) begin
      kind = KIND_BAD;
    end
  end

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;
  assign wdata_o    = {kind, bd, bn, ad, an};

endmodule

[rtl/rau_back.sv]
// rau_back: sequencer that carries out one item with a shared divider and multiplier
// depends on rau_pkg and rau_div
`timescale 1ns / 1ps

module rau_back #(
  parameter int unsigned W = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  logic [rau_pkg::KIND_W+4*W-1:0]       rdata_i,
  output logic                                 pop_o,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [rau_pkg::OUT_TDATA_W-1:0]      m_tdata_o,
  output logic                                 m_tuser_o
);

  import rau_pkg::*;

  localparam int unsigned DW = 2 * W + 2;
  localparam int unsigned MW = W + 1;

  state_e state_q, state_d;

  kind_e                kind_q;
  logic signed [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic signed [DW-1:0] x_q, y_q, t1_q, t2_q, t3_q, n_q, d_q;
  logic signed [MW-1:0] q1_q, q2_q, sq1, sq2, mul_a, mul_b;
  logic signed [DW-1:0] prod, div_a, div_b, div_q, div_r;
  logic signed [ORD_W-1:0] ord_q;
  logic                 red_q, div_start, div_done, out_load;

  logic                 out_valid_q;
  logic signed [OUT_W-1:0] res_num_q, res_den_q;
  logic signed [ORD_W-1:0] res_ord_q;
  logic                 res_ok_q;

  rau_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // l/a_den and l/b_den with l = |lcm|
  assign sq1  = (ad_q < 0) ? -((q1_q < 0) ? -q1_q : q1_q) : ((q1_q < 0) ? -q1_q : q1_q);
  assign sq2  = (bd_q < 0) ? -((q2_q < 0) ? -q2_q : q2_q) : ((q2_q < 0) ? -q2_q : q2_q);
  assign prod = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          case (kind_e'(rdata_i[KIND_W+4*W-1:4*W]))
            KIND_BAD:                     state_d = S_OUT;
            KIND_MUL, KIND_DIV:           state_d = S_M1;
            default:                      state_d = S_GCD_GO;
          endcase
        end
      end
      S_GCD_GO:   state_d = S_GCD_WAIT;
      S_GCD_WAIT: begin
        if (div_done) begin
          if (div_r != '0) state_d = S_GCD_GO;
          else if (red_q)  state_d = S_RN_GO;
          else             state_d = S_Q1_GO;
        end
      end
      S_Q1_GO:    state_d = S_Q1_WAIT;
      S_Q1_WAIT:  if (div_done) state_d = S_Q2_GO;
      S_Q2_GO:    state_d = S_Q2_WAIT;
      S_Q2_WAIT:  if (div_done) state_d = S_M1;
      S_M1:       state_d = S_M2;
      S_M2:       state_d = S_M3;
      S_M3:       state_d = S_FORM;
      S_FORM:     state_d = (kind_q == KIND_CMP) ? S_OUT : S_RCHK;
      S_RCHK:     state_d = (n_q == '0) ? S_OUT : S_GCD_GO;
      S_RN_GO:    state_d = S_RN_WAIT;
      S_RN_WAIT:  if (div_done) state_d = S_RD_GO;
      S_RD_GO:    state_d = S_RD_WAIT;
      S_RD_WAIT:  if (div_done) state_d = S_OUT;
      S_OUT:      if (!out_valid_q || m_tready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_a     = x_q;
    div_b     = y_q;
    mul_a     = MW'(an_q);
    mul_b     = q1_q;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE:   pop_o = !empty_i;
      S_GCD_GO: div_start = 1'b1;
      S_Q1_GO: begin
        div_start = 1'b1;
        div_a     = DW'(bd_q);
      end
      S_Q2_GO: begin
        div_start = 1'b1;
        div_a     = DW'(ad_q);
      end
      S_RN_GO: begin
        div_start = 1'b1;
        div_a     = n_q;
      end
      S_RD_GO: begin
        div_start = 1'b1;
        div_a     = d_q;
      end
      S_M1: begin
        case (kind_q)
          KIND_CMP: mul_b = sq1;
          KIND_MUL: mul_b = MW'(bn_q);
          KIND_DIV: mul_b = MW'(bd_q);
          default:  mul_b = q1_q;
        endcase
      end
      S_M2: begin
        case (kind_q)
          KIND_CMP: begin mul_a = MW'(bn_q); mul_b = sq2;       end
          KIND_MUL: begin mul_a = MW'(ad_q); mul_b = MW'(bd_q); end
          KIND_DIV: begin mul_a = MW'(ad_q); mul_b = MW'(bn_q); end
          default:  begin mul_a = MW'(bn_q); mul_b = q2_q;      end
        endcase
      end
      S_M3: begin
        mul_a = MW'(ad_q);
        mul_b = q1_q;
      end
      S_OUT:    out_load = !out_valid_q || m_tready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)        out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        kind_q <= kind_e'(rdata_i[KIND_W+4*W-1:4*W]);
        bd_q   <= rdata_i[4*W-1:3*W];
        bn_q   <= rdata_i[3*W-1:2*W];
        ad_q   <= rdata_i[2*W-1:W];
        an_q   <= rdata_i[W-1:0];
        x_q    <= DW'($signed(rdata_i[2*W-1:W]));
        y_q    <= DW'($signed(rdata_i[4*W-1:3*W]));
        red_q  <= 1'b0;
        ord_q  <= ORD_EQ;
      end
      S_GCD_WAIT: begin
        if (div_done && div_r != '0) begin
          x_q <= y_q;
          y_q <= div_r;
        end
      end
      S_Q1_WAIT: if (div_done) q1_q <= div_q[MW-1:0];
      S_Q2_WAIT: if (div_done) q2_q <= div_q[MW-1:0];
      S_M1: t1_q <= prod;
      S_M2: t2_q <= prod;
      S_M3: t3_q <= prod;
      S_FORM: begin
        case (kind_q)
          KIND_ADD: begin n_q <= t1_q + t2_q; d_q <= t3_q; end
          KIND_SUB: begin n_q <= t1_q - t2_q; d_q <= t3_q; end
          KIND_CMP: ord_q <= (t1_q < t2_q) ? ORD_LESS : ((t1_q == t2_q) ? ORD_EQ : ORD_GT);
          default:  begin n_q <= t1_q; d_q <= t2_q; end
        endcase
      end
      S_RCHK: begin
        x_q   <= n_q;
        y_q   <= d_q;
        red_q <= 1'b1;
      end
      S_RN_WAIT: if (div_done) n_q <= div_q;
      S_RD_WAIT: begin
        if (div_done) begin
          if (div_q < 0) begin
            n_q <= -n_q;
            d_q <= -div_q;
          end else begin
            d_q <= div_q;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (kind_q == KIND_BAD || kind_q == KIND_CMP) begin
            res_num_q <= '0;
            res_den_q <= '0;
          end else begin
            res_num_q <= OUT_W'(n_q);
            res_den_q <= OUT_W'(d_q);
          end
          res_ok_q  <= (kind_q != KIND_BAD);
          res_ord_q <= (kind_q == KIND_CMP) ? ord_q : ORD_EQ;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = res_ok_q;
  assign m_tdata_o  = {{(OUT_TDATA_W - 2*OUT_W - ORD_W){1'b0}}, res_ord_q, res_den_q, res_num_q};

endmodule

[rtl/rational_arithmetic_unit.sv]
// rational arithmetic unit: add, subtract, multiply, divide, compare of rationals
// one item at a time in the back; the divider is 34 bits wide at default width
// throughput set by the shared bit-serial divider used for gcd and exact division
// reset: asynchronous active low, clears queue, sequencer and output valid
// depends on rau_pkg, rau_fifo, rau_front, rau_back, rau_div
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input items
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // a_num, a_den, b_num, b_den from bit 0 up, zero padded to bytes
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // action
  input  logic [rau_pkg::ACT_W-1:0] s_axis_tuser_i,
  // result items
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // res_num, res_den, order from bit 0 up, zero padded
  output logic [rau_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // res_valid
  output logic m_axis_tuser_o
);

  import rau_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned IN_W = ((4 * W + 7) / 8) * 8;
  localparam int unsigned QW   = KIND_W + 4 * W;

  logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
  logic [QW-1:0] fifo_wdata, fifo_rdata;

  // front: handshake and classification of each item
  rau_front #(.W(W), .IN_W(IN_W)) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .full_i     (fifo_full),
    .push_o     (fifo_push),
    .wdata_o    (fifo_wdata)
  );

  // queue lets the front take items while the back is busy
  rau_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // back: gcd, cross products, reduction and the output register
  rau_back #(.W(W)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (fifo_empty),
    .rdata_i    (fifo_rdata),
    .pop_o      (fifo_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full) else $error("queue overflow");

  // never take an item out of an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty) else $error("queue underflow");

  // an invalid result carries all-zero data
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("invalid result with nonzero data");

endmodule
